// ----- rtl/cba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous bitmap allocator: request and
// response payloads, command and status codes, controller states.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int BLOCK_COUNT_DEF = 4096;

    // The map is held as words of one digit each; one digit is scanned a cycle.
    localparam int DIGIT_BITS  = 8;
    localparam int DIGIT_SHIFT = 3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] first_block;
        logic [12:0] run_length;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [11:0] granted_block;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/cba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/contiguous_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// After reset the map is cleared, one word a cycle, with the request side held not
// ready. An allocate scans the map word by word for the first free run of the
// requested length and then marks the granted run used, word by word; it answers
// not found when no run fits, and skips the scan for a zero length. A release
// clears its run word by word and skips that for a zero length. One request
// is in flight at a time; the next is taken the cycle after the result is registered.
// ----------------------------------------------------------------------------
// contiguous_bitmap_allocator
// First-fit allocator of runs of consecutive blocks over a used-block bitmap
// held in RAM, scanned one 8-bit digit per cycle.
// ----------------------------------------------------------------------------
module contiguous_bitmap_allocator #(
    parameter int BLOCK_COUNT = cba_pkg::BLOCK_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  cba_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output cba_pkg::t_rsp o_rsp
);

    localparam int DB = cba_pkg::DIGIT_BITS;
    localparam int DS = cba_pkg::DIGIT_SHIFT;
    localparam int NW = (BLOCK_COUNT + DB - 1) / DB;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int GW = AW + DS;                        // block index width
    localparam int EW = ((GW > 13) ? GW : 13) + 1;      // run end width
    localparam logic [GW:0]   BC_G = (GW + 1)'(BLOCK_COUNT);
    localparam logic [EW-1:0] BC_E = EW'(BLOCK_COUNT);
    localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

    cba_pkg::t_state r_state, n_state;

    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_scan_word, n_scan_word;
    logic [12:0]     r_run, n_run;
    logic [GW-1:0]   r_run_start, n_run_start;
    logic [12:0]     r_len, n_len;
    logic            r_cmd, n_cmd;
    logic [EW-1:0]   r_lo, n_lo;
    logic [EW-1:0]   r_hi, n_hi;
    logic [AW:0]     r_rd_word, n_rd_word;
    logic [AW-1:0]   r_wr_word, n_wr_word;
    logic            r_pend, n_pend;
    logic            r_status, n_status;
    logic [11:0]     r_granted, n_granted;
    logic            r_out_valid, n_out_valid;
    cba_pkg::t_rsp   r_out, n_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DB-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [DB-1:0]   ram_rdata;

    logic            req_fire;
    logic            rel_skip;
    logic [EW-1:0]   rel_sum;
    logic [EW-1:0]   rel_hi;
    logic            scan_found;
    logic [GW-1:0]   scan_start;
    logic [12:0]     scan_run;
    logic [GW-1:0]   scan_run_start;
    logic            rd_more;
    logic [DB-1:0]   word_mask;
    logic            out_free;

    cba_ram #(
        .WIDTH (DB),
        .DEPTH (NW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_req_ready = (r_state == cba_pkg::ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;

    // Release bounds: the run is cut at the end of the map.
    assign rel_sum  = EW'(i_req.first_block) + EW'(i_req.run_length);
    assign rel_hi   = (rel_sum > BC_E) ? BC_E : rel_sum;
    assign rel_skip = (i_req.run_length == 13'd0) || (EW'(i_req.first_block) >= BC_E);

    // Walk the current map word bit by bit, tracking the free run in progress.
    // Blocks beyond the end of the map count as used.
    always_comb begin
        logic [12:0]   run;
        logic [GW-1:0] st;
        logic          fnd;
        logic [GW-1:0] g;
        logic          free_bit;
        run = r_run;
        st  = r_run_start;
        fnd = 1'b0;
        for (int j = 0; j < DB; j++) begin
            g        = {r_scan_word, DS'(j)};
            free_bit = !ram_rdata[j] && ({1'b0, g} < BC_G);
            if (!fnd) begin
                if (free_bit) begin
                    if (run == 13'd0) begin
                        st = g;
                    end
                    run = run + 13'd1;
                    if (run == r_len) begin
                        fnd = 1'b1;
                    end
                end else begin
                    run = 13'd0;
                end
            end
        end
        scan_found     = fnd;
        scan_start     = st;
        scan_run       = run;
        scan_run_start = st;
    end

    // Bits of the word being written back that fall inside [lo, hi).
    always_comb begin
        logic [EW-1:0] g;
        for (int j = 0; j < DB; j++) begin
            g            = EW'({r_wr_word, DS'(j)});
            word_mask[j] = (g >= r_lo) && (g < r_hi);
        end
    end

    assign rd_more = (EW'({r_rd_word, {DS{1'b0}}}) < r_hi);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cba_pkg::ST_CLEAR: begin
                if (r_clr == LAST_WORD) begin
                    n_state = cba_pkg::ST_IDLE;
                end
            end
            cba_pkg::ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.cmd == cba_pkg::CMD_ALLOC) begin
                        n_state = (i_req.run_length == 13'd0) ? cba_pkg::ST_RESP
                                                               : cba_pkg::ST_SCAN;
                    end else begin
                        n_state = rel_skip ? cba_pkg::ST_RESP : cba_pkg::ST_MODIFY;
                    end
                end
            end
            cba_pkg::ST_SCAN: begin
                if (scan_found) begin
                    n_state = cba_pkg::ST_MODIFY;
                end else if (r_scan_word == LAST_WORD) begin
                    n_state = cba_pkg::ST_RESP;
                end
            end
            cba_pkg::ST_MODIFY: begin
                if (!rd_more) begin
                    n_state = cba_pkg::ST_RESP;
                end
            end
            cba_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = cba_pkg::ST_IDLE;
                end
            end
            default: n_state = cba_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_clr       = r_clr;
        n_scan_word = r_scan_word;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_len       = r_len;
        n_cmd       = r_cmd;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_rd_word   = r_rd_word;
        n_wr_word   = r_wr_word;
        n_pend      = r_pend;
        n_status    = r_status;
        n_granted   = r_granted;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_word;
        ram_wdata   = '0;
        ram_raddr   = '0;
        case (r_state)
            cba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
            end
            cba_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_cmd       = i_req.cmd;
                    n_len       = i_req.run_length;
                    n_scan_word = '0;
                    n_run       = '0;
                    n_run_start = '0;
                    n_pend      = 1'b0;
                    n_granted   = '0;
                    if (i_req.cmd == cba_pkg::CMD_ALLOC) begin
                        n_status = (i_req.run_length == 13'd0) ? cba_pkg::STATUS_NOT_FOUND
                                                                : cba_pkg::STATUS_OK;
                    end else begin
                        n_status  = cba_pkg::STATUS_OK;
                        n_lo      = EW'(i_req.first_block);
                        n_hi      = rel_hi;
                        n_rd_word = (AW + 1)'(i_req.first_block >> DS);
                    end
                end
            end
            cba_pkg::ST_SCAN: begin
                ram_raddr   = r_scan_word + AW'(1);
                n_scan_word = r_scan_word + AW'(1);
                n_run       = scan_run;
                n_run_start = scan_run_start;
                if (scan_found) begin
                    n_lo      = EW'(scan_start);
                    n_hi      = EW'(scan_start) + EW'(r_len);
                    n_rd_word = (AW + 1)'(scan_start >> DS);
                    n_granted = 12'(scan_start);
                    n_status  = cba_pkg::STATUS_OK;
                end else if (r_scan_word == LAST_WORD) begin
                    n_status = cba_pkg::STATUS_NOT_FOUND;
                end
            end
            cba_pkg::ST_MODIFY: begin
                // Read-modify-write, one word a cycle: the word read last cycle
                // is written while the next one is read.
                ram_we    = r_pend;
                ram_waddr = r_wr_word;
                ram_wdata = (r_cmd == cba_pkg::CMD_ALLOC) ? (ram_rdata | word_mask)
                                                          : (ram_rdata & ~word_mask);
                if (rd_more) begin
                    ram_raddr = r_rd_word[AW-1:0];
                    n_wr_word = r_rd_word[AW-1:0];
                    n_rd_word = r_rd_word + (AW + 1)'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            cba_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.granted_block = r_granted;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cba_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_word <= n_scan_word;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_len       <= n_len;
        r_cmd       <= n_cmd;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_rd_word   <= n_rd_word;
        r_wr_word   <= n_wr_word;
        r_status    <= n_status;
        r_granted   <= n_granted;
        r_out       <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ----- tb/contiguous_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_bitmap_allocator_tb
// Self-checking bench for the first-fit run allocator. A shadow copy of the
// used-block map predicts every response: the granted start of an allocate,
// not found where no run fits, and plain ok for a release. The bench runs a
// short directed sweep of the corner cases, then random traffic that
// allocates runs and hands them back, mixed with stray and oversized
// releases, under changing handshake idling and one long response stall.
// ----------------------------------------------------------------------------
module contiguous_bitmap_allocator_tb;

    localparam int BLK_COUNT    = cba_pkg::BLOCK_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int MAX_LIVE     = 40;

    typedef struct {
        int start;
        int len;
    } t_run;

    // Shadow of the used map together with the responses still owed by the block.
    class alloc_tracker;
        bit            shadow_map [BLK_COUNT];
        cba_pkg::t_rsp pending_rsp_q [$];
        int            mismatches;
        int            n_granted;
        int            n_refused;
        int            n_released;

        function new();
            foreach (shadow_map[i]) shadow_map[i] = 1'b0;
            mismatches = 0;
            n_granted  = 0;
            n_refused  = 0;
            n_released = 0;
        endfunction

        function cba_pkg::t_rsp note_request(cba_pkg::t_req r);
            cba_pkg::t_rsp rsp;
            int            run;
            int            run_start;
            int            len;
            int            first;
            rsp.status        = cba_pkg::STATUS_OK;
            rsp.granted_block = '0;
            len   = int'(r.run_length);
            first = int'(r.first_block);
            if (r.cmd == cba_pkg::CMD_ALLOC) begin
                rsp.status = cba_pkg::STATUS_NOT_FOUND;
                run        = 0;
                run_start  = 0;
                if (len != 0) begin
                    for (int b = 0; b < BLK_COUNT; b++) begin
                        if (!shadow_map[b]) begin
                            if (run == 0) run_start = b;
                            run++;
                            if (run == len) begin
                                for (int k = run_start; k < run_start + len; k++) begin
                                    shadow_map[k] = 1'b1;
                                end
                                rsp.status        = cba_pkg::STATUS_OK;
                                rsp.granted_block = run_start[11:0];
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (rsp.status == cba_pkg::STATUS_OK) n_granted++;
                else n_refused++;
            end else begin
                // Blocks at or beyond the end of the map are simply skipped.
                for (int k = first; k < first + len; k++) begin
                    if (k < BLK_COUNT) shadow_map[k] = 1'b0;
                end
                n_released++;
            end
            pending_rsp_q.push_back(rsp);
            return rsp;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(cba_pkg::t_rsp got);
            cba_pkg::t_rsp want;
            if (pending_rsp_q.size() == 0) begin
                report($sformatf("response status=%0d block=%0d with nothing outstanding",
                                 got.status, got.granted_block));
            end else begin
                want = pending_rsp_q.pop_front();
                if (got.status !== want.status) begin
                    report($sformatf("status %0d, predicted %0d", got.status, want.status));
                end
                if (got.granted_block !== want.granted_block) begin
                    report($sformatf("granted_block %0d, predicted %0d",
                                     got.granted_block, want.granted_block));
                end
            end
        endtask

        function int outstanding();
            return pending_rsp_q.size();
        endfunction
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    logic          o_req_ready;
    cba_pkg::t_req i_req       = '0;
    logic          o_rsp_valid;
    logic          i_rsp_ready = 1'b0;
    cba_pkg::t_rsp o_rsp;

    alloc_tracker tracker;
    t_run         live_runs [$];
    int           send_idle_pct = 28;
    int           recv_idle_pct = 60;
    int           random_sent   = 0;
    int           cycle_count   = 0;
    logic         hold_off      = 1'b0;

    contiguous_bitmap_allocator #(
        .BLOCK_COUNT(BLK_COUNT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses outstanding",
                     cycle_count, tracker.outstanding());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_ready) begin
            tracker.check_response(o_rsp);
        end
    end

    // Long response stall part-way through the random traffic, so that the
    // block backs up and holds off further requests.
    initial begin
        wait (random_sent >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_request(input cba_pkg::t_req r, output cba_pkg::t_rsp predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            i_req       <= cba_pkg::t_req'($urandom);
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_ready !== 1'b1) @(posedge i_clk);
        predicted = tracker.note_request(r);
    endtask

    task automatic alloc_run(input int len);
        cba_pkg::t_req r;
        cba_pkg::t_rsp predicted;
        t_run          run;
        r.cmd         = cba_pkg::CMD_ALLOC;
        r.first_block = 12'($urandom_range(4095));
        r.run_length  = len[12:0];
        send_request(r, predicted);
        if (predicted.status == cba_pkg::STATUS_OK) begin
            run.start = int'(predicted.granted_block);
            run.len   = len;
            live_runs.push_back(run);
        end
    endtask

    task automatic release_run(input int first, input int len);
        cba_pkg::t_req r;
        cba_pkg::t_rsp predicted;
        r.cmd         = cba_pkg::CMD_RELEASE;
        r.first_block = first[11:0];
        r.run_length  = len[12:0];
        send_request(r, predicted);
    endtask

    function automatic int pick_alloc_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68) return $urandom_range(32, 1);
        if (pick < 88) return $urandom_range(512, 33);
        if (pick < 96) return $urandom_range(4096, 513);
        if (pick < 98) return $urandom_range(8191, 4097);
        return 0;
    endfunction

    task automatic release_live_run();
        int   idx;
        int   offset;
        t_run run;
        idx = $urandom_range(live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        if ($urandom_range(99) < 15 && run.len > 1) begin
            // Hand back only part of the run; the rest stays used until a
            // wider release sweeps it up.
            offset = $urandom_range(run.len - 1);
            release_run(run.start + offset, $urandom_range(run.len - offset, 1));
        end else begin
            release_run(run.start, run.len);
        end
    endtask

    task automatic stray_release();
        if ($urandom_range(3) == 0) begin
            release_run($urandom_range(4095), $urandom_range(8191));
        end else begin
            release_run($urandom_range(4095), $urandom_range(64));
        end
    endtask

    task automatic run_directed();
        alloc_run(0);                   // zero-length allocate is refused
        alloc_run(1);
        alloc_run(4095);                // fills the map
        alloc_run(1);                   // nothing left
        release_run(0, 8191);           // runs past the end of the map
        alloc_run(4096);                // whole map in one run
        release_run(4095, 1);
        alloc_run(2);
        alloc_run(1);                   // only the last block is free
        release_run(4095, 8191);        // from the last block past the end
        release_run(100, 0);            // zero-length release
        release_run(0, 4096);
        alloc_run(4097);                // longer than the map
        alloc_run(8191);
        alloc_run(10);
        alloc_run(10);
        release_run(0, 10);
        release_run(0, 10);             // blocks already free
        alloc_run(5);
        alloc_run(8);                   // hole of five is too small
        alloc_run(5);                   // fills the hole exactly
        release_run(0, 4096);
        live_runs.delete();
    endtask

    task automatic run_random();
        int pick;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 3 / RANDOM_ITEMS)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            pick = $urandom_range(99);
            if (live_runs.size() == 0 || (pick < 50 && live_runs.size() < MAX_LIVE)) begin
                alloc_run(pick_alloc_length());
            end else if (pick < 90) begin
                release_live_run();
            end else begin
                stray_release();
            end
            random_sent++;
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();
        i_req_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            tracker.report($sformatf("%0d responses never arrived", tracker.outstanding()));
        end

        $display("Run covered %0d grants, %0d refused allocates and %0d releases.",
                 tracker.n_granted, tracker.n_refused, tracker.n_released);
        $display("Idling went from slow receiver to slow sender to none, with one %0d-cycle stall.",
                 HOLD_CYCLES);
        if (tracker.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cba_pkg.sv
rtl/cba_ram.sv
rtl/contiguous_bitmap_allocator.sv
tb/contiguous_bitmap_allocator_tb.sv
